>>> src/dcwa_pkg.sv
// Shared types and constants for the descriptor cache with aging.
package dcwa_pkg;

   localparam int ENTRIES_DEF     = 64;
   localparam int PAYLOAD_MAX_DEF = 512;
   localparam int SLOT_W          = 6;
   localparam int CNT_W           = 7;
   localparam int PAY_W           = 10;
   localparam int KIND_W          = 3;
   localparam int CSR_IDX_W       = 8;
   localparam int TIME_W          = 64;

   localparam logic [KIND_W-1:0] KIND_INSERT   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FIND     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_EXPIRE   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DISPATCH = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_AGE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_REQ = 8'd1;

   localparam logic [TIME_W-1:0] MAX_AGE_RST = 64'd10000;
   localparam logic [TIME_W-1:0] MIN_REQ_RST = 64'd1000;

   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_UPDATED  = 3'd1,
      ST_FULL     = 3'd2,
      ST_FOUND    = 3'd3,
      ST_MISS     = 3'd4,
      ST_REMOVED  = 3'd5,
      ST_REQUEST  = 3'd6,
      ST_IDLE     = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      OP_INSERT,
      OP_FIND,
      OP_CLEAR,
      OP_EXPIRE,
      OP_DISPATCH,
      OP_NOP
   } op_type;

   typedef struct packed {
      logic [63:0] model_id;
      logic [63:0] entity;
      logic [15:0] config_number;
      logic [15:0] desc_type;
      logic [15:0] desc_index;
   } key_type;

   typedef struct packed {
      key_type           key;
      logic [TIME_W-1:0] upd_time;
      logic [TIME_W-1:0] req_time;
      logic [PAY_W-1:0]  pay;
   } entry_type;

   typedef struct packed {
      op_type            op;
      logic [TIME_W-1:0] now;
      key_type           key;
      logic [PAY_W-1:0]  pay;
      logic [CNT_W-1:0]  credit;
   } cmd_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot;
      key_type           key;
      logic [PAY_W-1:0]  pay;
      logic [CNT_W-1:0]  removed;
      logic              last;
   } res_type;

endpackage

>>> src/dcwa_ifs.sv
// Request, response and register-write channel interfaces.
interface dcwa_req_if;
   import dcwa_pkg::*;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [TIME_W-1:0]   now_ms;
   logic [63:0]         model_id;
   logic [63:0]         entity;
   logic [15:0]         config_number;
   logic [15:0]         desc_type;
   logic [15:0]         desc_index;
   logic [PAY_W-1:0]    payload_bytes;
   logic [CNT_W-1:0]    request_credit;
   modport source (output valid, kind, now_ms, model_id, entity, config_number, desc_type,
                   desc_index, payload_bytes, request_credit, input ready);
   modport sink (input valid, kind, now_ms, model_id, entity, config_number, desc_type,
                 desc_index, payload_bytes, request_credit, output ready);
endinterface

interface dcwa_rsp_if;
   import dcwa_pkg::*;
   logic                valid;
   logic                ready;
   logic [2:0]          status;
   logic [SLOT_W-1:0]   slot;
   logic [63:0]         out_model_id;
   logic [63:0]         out_entity;
   logic [15:0]         out_config_number;
   logic [15:0]         out_desc_type;
   logic [15:0]         out_desc_index;
   logic [PAY_W-1:0]    out_payload_bytes;
   logic [CNT_W-1:0]    removed_count;
   logic [CNT_W-1:0]    entry_count;
   logic                last;
   modport source (output valid, status, slot, out_model_id, out_entity, out_config_number,
                   out_desc_type, out_desc_index, out_payload_bytes, removed_count,
                   entry_count, last, input ready);
   modport sink (input valid, status, slot, out_model_id, out_entity, out_config_number,
                 out_desc_type, out_desc_index, out_payload_bytes, removed_count,
                 entry_count, last, output ready);
endinterface

interface dcwa_csr_if;
   import dcwa_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [TIME_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> src/dcwa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dcwa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> src/dcwa_front.sv
// Front end: takes requests, decodes the command and queues it for the table engine.
module dcwa_front #(
   parameter int PAYLOAD_MAX = dcwa_pkg::PAYLOAD_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   dcwa_req_if.sink          req,
   output logic              cmd_valid,
   output dcwa_pkg::cmd_type cmd,
   input  logic              cmd_pop
);
   import dcwa_pkg::*;

   localparam int CMP_W = 13;

   cmd_type     q_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   cmd_type     dec;
   logic        push;

   always_comb begin
      unique case (req.kind)
         KIND_INSERT:   dec.op = OP_INSERT;
         KIND_FIND:     dec.op = OP_FIND;
         KIND_CLEAR:    dec.op = OP_CLEAR;
         KIND_EXPIRE:   dec.op = OP_EXPIRE;
         KIND_DISPATCH: dec.op = OP_DISPATCH;
         default:       dec.op = OP_NOP;
      endcase
      dec.now               = req.now_ms;
      dec.key.model_id      = req.model_id;
      dec.key.entity        = req.entity;
      dec.key.config_number = req.config_number;
      dec.key.desc_type     = req.desc_type;
      dec.key.desc_index    = req.desc_index;
      // oversized lengths are stored as the maximum
      if (CMP_W'(req.payload_bytes) > CMP_W'(PAYLOAD_MAX)) begin
         dec.pay = PAY_W'(PAYLOAD_MAX);
      end else begin
         dec.pay = req.payload_bytes;
      end
      dec.credit = req.request_credit;
   end

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ cmd_pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end
endmodule

>>> src/dcwa_back.sv
// Table engine: walks, shifts and compacts the sorted table and builds responses.
module dcwa_back #(
   parameter int ENTRIES = dcwa_pkg::ENTRIES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   input  dcwa_pkg::cmd_type           cmd,
   output logic                        cmd_pop,
   input  logic [dcwa_pkg::TIME_W-1:0] max_age,
   input  logic [dcwa_pkg::TIME_W-1:0] min_req,
   output logic                        out_valid,
   output dcwa_pkg::res_type           out_res,
   output logic [dcwa_pkg::CNT_W-1:0]  out_count,
   input  logic                        out_ready
);
   import dcwa_pkg::*;

   localparam int AW = $clog2(ENTRIES);
   localparam int IW = $clog2(ENTRIES + 1);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_RD   = 7'b0000010,
      S_EX   = 7'b0000100,
      S_END  = 7'b0001000,
      S_MVRD = 7'b0010000,
      S_MVEX = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [IW-1:0]    wr_ff, wr_in;
   logic [IW-1:0]    pos_ff, pos_in;
   logic [IW-1:0]    used_ff, used_in;
   logic [CNT_W-1:0] removed_ff, removed_in;
   logic [CNT_W-1:0] credit_ff, credit_in;
   res_type          pend_ff, pend_in;
   logic             have_pend_ff, have_pend_in;
   res_type          res_ff, res_in;
   logic             cont_ff, cont_in;
   logic             dend_ff, dend_in;
   logic             out_valid_ff, out_valid_in;
   res_type          out_ff, out_in;
   logic [CNT_W-1:0] out_count_ff, out_count_in;

   logic             ram_we;
   logic [AW-1:0]    ram_waddr, ram_raddr;
   entry_type        ram_wdata, ram_rdata, ent;
   logic [IW-1:0]    nidx;
   logic             stale, drop, dn;

   dcwa_ram #(.WIDTH($bits(entry_type)), .DEPTH(ENTRIES)) u_ram (
      .clock(clock), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
      .raddr(ram_raddr), .rdata(ram_rdata)
   );

   assign ent   = ram_rdata;
   assign nidx  = IW'(idx_ff + 1'b1);
   assign stale = (cmd_ff.now - ent.req_time) > min_req;
   assign drop  = (cmd_ff.op == OP_CLEAR) ? (ent.key.entity == cmd_ff.key.entity)
                                          : ((cmd_ff.now - ent.upd_time) > max_age);
   assign dn    = (nidx == used_ff) || (stale && credit_ff == CNT_W'(1));

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      wr_in        = wr_ff;
      pos_in       = pos_ff;
      used_in      = used_ff;
      removed_in   = removed_ff;
      credit_in    = credit_ff;
      pend_in      = pend_ff;
      have_pend_in = have_pend_ff;
      res_in       = res_ff;
      cont_in      = cont_ff;
      dend_in      = dend_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_in       = out_ff;
      out_count_in = out_count_ff;
      cmd_pop      = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff[AW-1:0];
      ram_wdata    = ent;
      ram_raddr    = idx_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop      = 1'b1;
               cmd_in       = cmd;
               idx_in       = '0;
               wr_in        = '0;
               pos_in       = '0;
               removed_in   = '0;
               credit_in    = cmd.credit;
               have_pend_in = 1'b0;
               if (cmd.op == OP_NOP || used_ff == '0 ||
                   (cmd.op == OP_DISPATCH && cmd.credit == '0)) begin
                  state_in = S_END;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            state_in = S_EX;
         end
         S_EX: begin
            idx_in = nidx;
            unique case (cmd_ff.op)
               OP_INSERT, OP_FIND: begin
                  if (ent.key >= cmd_ff.key) begin
                     if (ent.key == cmd_ff.key) begin
                        res_in.slot    = SLOT_W'(idx_ff);
                        res_in.key     = ent.key;
                        res_in.removed = '0;
                        res_in.last    = 1'b1;
                        cont_in        = 1'b0;
                        state_in       = S_OUT;
                        if (cmd_ff.op == OP_INSERT) begin
                           ram_we             = 1'b1;
                           ram_wdata.upd_time = cmd_ff.now;
                           ram_wdata.req_time = cmd_ff.now;
                           ram_wdata.pay      = cmd_ff.pay;
                           res_in.status      = ST_UPDATED;
                           res_in.pay         = cmd_ff.pay;
                        end else begin
                           res_in.status = ST_FOUND;
                           res_in.pay    = ent.pay;
                        end
                     end else begin
                        pos_in   = idx_ff;
                        state_in = S_END;
                     end
                  end else if (nidx == used_ff) begin
                     pos_in   = used_ff;
                     state_in = S_END;
                  end else begin
                     state_in = S_RD;
                  end
               end
               OP_CLEAR, OP_EXPIRE: begin
                  if (drop) begin
                     removed_in = removed_ff + 1'b1;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = wr_ff[AW-1:0];
                     wr_in     = IW'(wr_ff + 1'b1);
                  end
                  state_in = (nidx == used_ff) ? S_END : S_RD;
               end
               OP_DISPATCH: begin
                  state_in = dn ? S_END : S_RD;
                  if (stale) begin
                     ram_we             = 1'b1;
                     ram_wdata.req_time = cmd_ff.now;
                     credit_in          = credit_ff - 1'b1;
                     pend_in.status     = ST_REQUEST;
                     pend_in.slot       = SLOT_W'(idx_ff);
                     pend_in.key        = ent.key;
                     pend_in.pay        = ent.pay;
                     pend_in.removed    = '0;
                     pend_in.last       = 1'b0;
                     have_pend_in       = 1'b1;
                     // an earlier request goes out only once a later one is known
                     if (have_pend_ff) begin
                        res_in   = pend_ff;
                        cont_in  = 1'b1;
                        dend_in  = dn;
                        state_in = S_OUT;
                     end
                  end
               end
               default: state_in = S_END;
            endcase
         end
         S_END: begin
            res_in.slot    = '0;
            res_in.key     = cmd_ff.key;
            res_in.pay     = '0;
            res_in.removed = '0;
            res_in.last    = 1'b1;
            cont_in        = 1'b0;
            state_in       = S_OUT;
            unique case (cmd_ff.op)
               OP_INSERT: begin
                  if (used_ff == IW'(ENTRIES)) begin
                     res_in.status = ST_FULL;
                  end else begin
                     wr_in    = used_ff;
                     state_in = S_MVRD;
                  end
               end
               OP_FIND: res_in.status = ST_MISS;
               OP_CLEAR, OP_EXPIRE: begin
                  used_in        = wr_ff;
                  res_in.status  = ST_REMOVED;
                  res_in.key     = '0;
                  res_in.removed = removed_ff;
                  if (cmd_ff.op == OP_CLEAR) begin
                     res_in.key.entity = cmd_ff.key.entity;
                  end
               end
               OP_DISPATCH: begin
                  if (have_pend_ff) begin
                     res_in      = pend_ff;
                     res_in.last = 1'b1;
                  end else begin
                     res_in.status = ST_IDLE;
                     res_in.key    = '0;
                  end
               end
               default: begin
                  res_in.status = ST_IDLE;
                  res_in.key    = '0;
               end
            endcase
         end
         S_MVRD: begin
            ram_raddr = wr_ff[AW-1:0] - 1'b1;
            if (wr_ff == pos_ff) begin
               ram_we             = 1'b1;
               ram_waddr          = pos_ff[AW-1:0];
               ram_wdata.key      = cmd_ff.key;
               ram_wdata.upd_time = cmd_ff.now;
               ram_wdata.req_time = cmd_ff.now;
               ram_wdata.pay      = cmd_ff.pay;
               used_in            = IW'(used_ff + 1'b1);
               res_in.status      = ST_INSERTED;
               res_in.slot        = SLOT_W'(pos_ff);
               res_in.key         = cmd_ff.key;
               res_in.pay         = cmd_ff.pay;
               res_in.removed     = '0;
               res_in.last        = 1'b1;
               cont_in            = 1'b0;
               state_in           = S_OUT;
            end else begin
               state_in = S_MVEX;
            end
         end
         S_MVEX: begin
            ram_we    = 1'b1;
            ram_waddr = wr_ff[AW-1:0];
            wr_in     = wr_ff - 1'b1;
            state_in  = S_MVRD;
         end
         S_OUT: begin
            if (!out_valid_ff || out_ready) begin
               out_valid_in = 1'b1;
               out_in       = res_ff;
               out_count_in = CNT_W'(used_ff);
               if (cont_ff) begin
                  state_in = dend_ff ? S_END : S_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         out_valid_ff <= 1'b0;
         have_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         out_valid_ff <= out_valid_in;
         have_pend_ff <= have_pend_in;
      end
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      wr_ff        <= wr_in;
      pos_ff       <= pos_in;
      removed_ff   <= removed_in;
      credit_ff    <= credit_in;
      pend_ff      <= pend_in;
      res_ff       <= res_in;
      cont_ff      <= cont_in;
      dend_ff      <= dend_in;
      out_ff       <= out_in;
      out_count_ff <= out_count_in;
   end

   assign out_valid = out_valid_ff;
   assign out_res   = out_ff;
   assign out_count = out_count_ff;
endmodule

>>> src/descriptor_cache_with_aging_core.sv
// Top level of the descriptor cache with aging.
// A sorted table of up to ENTRIES descriptor keys with update/request times.
// Channels: req_bus carries commands (insert/update, find, clear entity, expire,
// dispatch), rsp_bus returns responses, csr_bus writes max_age_ms (index 0)
// and min_request_interval_ms (index 1); csr_bus is always ready.
// A two-deep command queue sits in front of the table engine, so up to two
// commands are taken while the engine is busy.
// Each table entry visited costs a RAM read, then a compare or move, all in
// the single-port-read table RAM. Find/update scans up to the matching slot;
// a miss or a full table scans up to the insert point. Insert: scan, then each
// entry above the insert point is shifted up one slot. Clear and expire walk
// all used entries. Dispatch emits its requests during the walk of the table;
// the walk stops once the credit is spent.
// Every command yields one response, except dispatch, which yields one per
// re-requested entry (last set on the final one) or a single idle response.
// Reset empties the table at once (no clearing pass) and restores the register
// defaults. A stalled rsp_bus holds its response; the engine waits on it,
// while the queue keeps taking commands until full.
module descriptor_cache_with_aging_core #(
   parameter int ENTRIES     = dcwa_pkg::ENTRIES_DEF,
   parameter int PAYLOAD_MAX = dcwa_pkg::PAYLOAD_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   dcwa_req_if.sink   req_bus,
   dcwa_rsp_if.source rsp_bus,
   dcwa_csr_if.sink   csr_bus
);
   import dcwa_pkg::*;

   logic [TIME_W-1:0] max_age_ff, max_age_in;
   logic [TIME_W-1:0] min_req_ff, min_req_in;
   logic              cmd_valid, cmd_pop;
   cmd_type           cmd;
   res_type           res;
   logic [CNT_W-1:0]  count;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      max_age_in = max_age_ff;
      min_req_in = min_req_ff;
      if (csr_bus.valid) begin
         if (csr_bus.index == REG_MAX_AGE) begin
            max_age_in = csr_bus.data;
         end
         if (csr_bus.index == REG_MIN_REQ) begin
            min_req_in = csr_bus.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff <= MAX_AGE_RST;
         min_req_ff <= MIN_REQ_RST;
      end else begin
         max_age_ff <= max_age_in;
         min_req_ff <= min_req_in;
      end
   end

   dcwa_front #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_front (
      .clock(clock), .reset(reset), .req(req_bus),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
   );

   dcwa_back #(.ENTRIES(ENTRIES)) u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
      .max_age(max_age_ff), .min_req(min_req_ff),
      .out_valid(rsp_bus.valid), .out_res(res), .out_count(count),
      .out_ready(rsp_bus.ready)
   );

   assign rsp_bus.status            = res.status;
   assign rsp_bus.slot              = res.slot;
   assign rsp_bus.out_model_id      = res.key.model_id;
   assign rsp_bus.out_entity        = res.key.entity;
   assign rsp_bus.out_config_number = res.key.config_number;
   assign rsp_bus.out_desc_type     = res.key.desc_type;
   assign rsp_bus.out_desc_index    = res.key.desc_index;
   assign rsp_bus.out_payload_bytes = res.pay;
   assign rsp_bus.removed_count     = res.removed;
   assign rsp_bus.entry_count       = count;
   assign rsp_bus.last              = res.last;
endmodule

>>> src/dcwa_checker.sv
// Port-level checks on the response channel, bound to the top level.
module dcwa_checker #(
   parameter int ENTRIES = dcwa_pkg::ENTRIES_DEF
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [2:0]                 status,
   input logic [dcwa_pkg::CNT_W-1:0] removed_count,
   input logic [dcwa_pkg::CNT_W-1:0] entry_count,
   input logic                       last
);
   import dcwa_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> entry_count <= CNT_W'(ENTRIES))
      else $error("entry count above capacity");

   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != ST_REQUEST |-> last)
      else $error("single-response command without last");

   a_removed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && removed_count != '0 |-> status == ST_REMOVED)
      else $error("removed count on a non-removal response");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == ST_FULL |-> entry_count == CNT_W'(ENTRIES))
      else $error("full reported with free slots");
endmodule

bind descriptor_cache_with_aging_core dcwa_checker #(.ENTRIES(ENTRIES)) u_dcwa_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_bus.valid), .rsp_ready(rsp_bus.ready),
   .status(rsp_bus.status), .removed_count(rsp_bus.removed_count),
   .entry_count(rsp_bus.entry_count), .last(rsp_bus.last)
);

>>> dv/testbench.sv
// Self-checking testbench for the descriptor cache with aging core.
`timescale 1ns / 100ps

module testbench;
   import dcwa_pkg::*;

   localparam int NSLOTS       = ENTRIES_DEF;
   localparam int PAY_CAP      = PAYLOAD_MAX_DEF;
   localparam int SETTLE_CYC   = 600;
   localparam int WATCHDOG_CYC = 20000;
   localparam int LONG_HOLD    = 400;
   localparam logic [KIND_W-1:0] KIND_RSV5 = 3'd5;
   localparam logic [KIND_W-1:0] KIND_RSV6 = 3'd6;
   localparam logic [KIND_W-1:0] KIND_RSV7 = 3'd7;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [63:0]       now;
      key_type           key;
      logic [PAY_W-1:0]  pay;
      logic [CNT_W-1:0]  credit;
   } cmd_item;

   typedef struct {
      logic [2:0]        status;
      logic [SLOT_W-1:0] slot;
      key_type           key;
      logic [PAY_W-1:0]  pay;
      logic [CNT_W-1:0]  removed;
      logic [CNT_W-1:0]  count;
      logic              last;
   } rsp_item;

   logic clock, reset;
   dcwa_req_if req_if();
   dcwa_rsp_if rsp_if();
   dcwa_csr_if csr_if();

   descriptor_cache_with_aging_core dut (
      .clock(clock), .reset(reset),
      .req_bus(req_if), .rsp_bus(rsp_if), .csr_bus(csr_if)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // shadow of the table
   key_type          tkey [NSLOTS];
   logic [63:0]      tupd [NSLOTS];
   logic [63:0]      treq [NSLOTS];
   logic [PAY_W-1:0] tpay [NSLOTS];
   int               tused;
   logic [63:0]      max_age, min_req;

   cmd_item pending [$];
   rsp_item expected_rsp [$];
   int  errors, mismatches;
   bit  send_pause, no_idle;
   int  hold_kick;
   int  idle_cyc;
   logic [63:0] cur_time;

   function automatic void push_rsp(logic [2:0] st, int slot, key_type k, logic [PAY_W-1:0] p,
                                    int removed, logic last);
      rsp_item r;
      r.status = st; r.slot = slot[SLOT_W-1:0]; r.key = k; r.pay = p;
      r.removed = removed[CNT_W-1:0]; r.count = tused[CNT_W-1:0]; r.last = last;
      expected_rsp.push_back(r);
   endfunction

   function automatic void table_step(cmd_item c);
      int pos, w, removed, lastk, credit;
      logic [PAY_W-1:0] p;
      bit drop;
      key_type zk;
      zk = '0;
      p = (c.pay > PAY_CAP) ? PAY_W'(PAY_CAP) : c.pay;
      case (c.kind)
         KIND_INSERT, KIND_FIND: begin
            pos = tused;
            for (int i = 0; i < tused; i++)
               if (tkey[i] >= c.key) begin
                  pos = i;
                  break;
               end
            if (pos < tused && tkey[pos] == c.key) begin
               if (c.kind == KIND_INSERT) begin
                  tupd[pos] = c.now; treq[pos] = c.now; tpay[pos] = p;
                  push_rsp(ST_UPDATED, pos, tkey[pos], tpay[pos], 0, 1'b1);
               end else
                  push_rsp(ST_FOUND, pos, tkey[pos], tpay[pos], 0, 1'b1);
            end else if (c.kind == KIND_FIND)
               push_rsp(ST_MISS, 0, c.key, '0, 0, 1'b1);
            else if (tused >= NSLOTS)
               push_rsp(ST_FULL, 0, c.key, '0, 0, 1'b1);
            else begin
               for (int i = tused; i > pos; i--) begin
                  tkey[i] = tkey[i-1]; tupd[i] = tupd[i-1];
                  treq[i] = treq[i-1]; tpay[i] = tpay[i-1];
               end
               tkey[pos] = c.key; tupd[pos] = c.now; treq[pos] = c.now; tpay[pos] = p;
               tused++;
               push_rsp(ST_INSERTED, pos, tkey[pos], tpay[pos], 0, 1'b1);
            end
         end
         KIND_CLEAR, KIND_EXPIRE: begin
            w = 0; removed = 0;
            for (int i = 0; i < tused; i++) begin
               drop = (c.kind == KIND_CLEAR) ? (tkey[i].entity == c.key.entity)
                                             : ((c.now - tupd[i]) > max_age);
               if (drop) removed++;
               else begin
                  tkey[w] = tkey[i]; tupd[w] = tupd[i]; treq[w] = treq[i]; tpay[w] = tpay[i];
                  w++;
               end
            end
            tused = w;
            if (c.kind == KIND_CLEAR) zk.entity = c.key.entity;
            push_rsp(ST_REMOVED, 0, zk, '0, removed, 1'b1);
         end
         KIND_DISPATCH: begin
            lastk = -1; credit = int'(c.credit);
            for (int i = 0; i < tused && credit > 0; i++)
               if ((c.now - treq[i]) > min_req) begin
                  treq[i] = c.now;
                  push_rsp(ST_REQUEST, i, tkey[i], tpay[i], 0, 1'b0);
                  lastk = expected_rsp.size() - 1;
                  credit--;
               end
            if (lastk >= 0) expected_rsp[lastk].last = 1'b1;
            else push_rsp(ST_IDLE, 0, zk, '0, 0, 1'b1);
         end
         default: push_rsp(ST_IDLE, 0, zk, '0, 0, 1'b1);
      endcase
   endfunction

   // request driver
   cmd_item drv_cur;
   bit drv_offered;
   int drv_gap;
   always @(posedge clock) begin
      logic nv;
      nv = 1'b0;
      if (reset) begin
         drv_offered = 0; drv_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            table_step(drv_cur);
            void'(pending.pop_front());
            drv_offered = 0;
            if (!no_idle && $urandom_range(0, 3) == 0) drv_gap = $urandom_range(1, 8);
         end
         if (drv_offered) nv = 1'b1;
         else if (drv_gap > 0) drv_gap--;
         else if (pending.size() > 0 && !send_pause) begin
            drv_cur = pending[0];
            drv_offered = 1;
            nv = 1'b1;
            req_if.kind <= drv_cur.kind;
            req_if.now_ms <= drv_cur.now;
            req_if.model_id <= drv_cur.key.model_id;
            req_if.entity <= drv_cur.key.entity;
            req_if.config_number <= drv_cur.key.config_number;
            req_if.desc_type <= drv_cur.key.desc_type;
            req_if.desc_index <= drv_cur.key.desc_index;
            req_if.payload_bytes <= drv_cur.pay;
            req_if.request_credit <= drv_cur.credit;
         end
      end
      req_if.valid <= nv;
   end

   // response monitor, ready pacing and watchdog
   int mon_gap, hold_left, kick_seen;
   always @(posedge clock) begin
      logic nr;
      rsp_item e;
      nr = 1'b0;
      if (reset) begin
         mon_gap = 0; hold_left = 0; kick_seen = 0; idle_cyc = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_rsp.size() == 0) begin
               errors++;
               if (mismatches++ < 10)
                  $display("unexpected response status=%0d slot=%0d", rsp_if.status, rsp_if.slot);
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_if.status !== e.status || rsp_if.slot !== e.slot
                   || rsp_if.out_model_id !== e.key.model_id
                   || rsp_if.out_entity !== e.key.entity
                   || rsp_if.out_config_number !== e.key.config_number
                   || rsp_if.out_desc_type !== e.key.desc_type
                   || rsp_if.out_desc_index !== e.key.desc_index
                   || rsp_if.out_payload_bytes !== e.pay
                   || rsp_if.removed_count !== e.removed
                   || rsp_if.entry_count !== e.count || rsp_if.last !== e.last) begin
                  errors++;
                  if (mismatches++ < 10) begin
                     $display("mismatch exp: st=%0d slot=%0d key=%h pay=%0d rm=%0d cnt=%0d last=%0d",
                              e.status, e.slot, e.key, e.pay, e.removed, e.count, e.last);
                     $display("         act: st=%0d slot=%0d key=%h%h%h%h%h pay=%0d rm=%0d cnt=%0d last=%0d",
                              rsp_if.status, rsp_if.slot, rsp_if.out_model_id, rsp_if.out_entity,
                              rsp_if.out_config_number, rsp_if.out_desc_type,
                              rsp_if.out_desc_index, rsp_if.out_payload_bytes,
                              rsp_if.removed_count, rsp_if.entry_count, rsp_if.last);
                  end
               end
            end
            if (!no_idle && $urandom_range(0, 3) == 0) mon_gap = $urandom_range(1, 8);
         end
         if (kick_seen != hold_kick) begin
            kick_seen = hold_kick;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) hold_left--;
         else if (mon_gap > 0) mon_gap--;
         else nr = 1'b1;

         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
             || (pending.size() == 0 && expected_rsp.size() == 0))
            idle_cyc = 0;
         else if (++idle_cyc >= WATCHDOG_CYC) begin
            $display("status: fail");
            $finish;
         end
      end
      rsp_if.ready <= nr;
   end

   function automatic key_type pool_key();
      key_type k;
      if ($urandom_range(0, 7) == 0)
         k = {{$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom), 16'($urandom),
              16'($urandom)};
      else begin
         case ($urandom_range(0, 2))
            0: k.model_id = '0;
            1: k.model_id = '1;
            default: k.model_id = 64'd5;
         endcase
         case ($urandom_range(0, 3))
            0: k.entity = '0;
            1: k.entity = '1;
            2: k.entity = 64'd7;
            default: k.entity = 64'd9;
         endcase
         k.config_number = 16'($urandom_range(0, 2));
         k.desc_type = 16'($urandom_range(0, 2));
         k.desc_index = 16'($urandom_range(0, 2));
      end
      return k;
   endfunction

   function automatic cmd_item make_cmd(logic [KIND_W-1:0] kind);
      cmd_item c;
      if ($urandom_range(0, 19) == 0) cur_time = {$urandom, $urandom};
      else cur_time += $urandom_range(0, 1500);
      c.kind = kind; c.now = cur_time; c.key = pool_key();
      c.pay = ($urandom_range(0, 3) == 0) ? PAY_W'($urandom) : PAY_W'($urandom_range(0, 512));
      c.credit = ($urandom_range(0, 4) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(0, 64));
      return c;
   endfunction

   function automatic logic [KIND_W-1:0] rand_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return KIND_INSERT;
      if (r < 60) return KIND_FIND;
      if (r < 68) return KIND_CLEAR;
      if (r < 78) return KIND_EXPIRE;
      if (r < 95) return KIND_DISPATCH;
      case ($urandom_range(0, 2))
         0: return KIND_RSV5;
         1: return KIND_RSV6;
         default: return KIND_RSV7;
      endcase
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] val);
      @(posedge clock);
      csr_if.valid <= 1'b1; csr_if.index <= idx; csr_if.data <= val;
      do @(posedge clock); while (!csr_if.ready);
      if (idx == REG_MAX_AGE) max_age = val;
      else if (idx == REG_MIN_REQ) min_req = val;
      csr_if.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending.size() > 0 || expected_rsp.size() > 0 || req_if.valid) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic add_cmd(cmd_item c);
      pending.push_back(c);
   endtask

   task automatic add_random(int n);
      for (int i = 0; i < n; i++) add_cmd(make_cmd(rand_kind()));
   endtask

   initial begin
      cmd_item c;
      reset = 1'b1;
      req_if.valid = 1'b0; req_if.kind = '0; req_if.now_ms = '0; req_if.model_id = '0;
      req_if.entity = '0; req_if.config_number = '0; req_if.desc_type = '0;
      req_if.desc_index = '0; req_if.payload_bytes = '0; req_if.request_credit = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0; csr_if.index = '0; csr_if.data = '0;
      tused = 0; max_age = MAX_AGE_RST; min_req = MIN_REQ_RST;
      errors = 0; mismatches = 0; send_pause = 0; no_idle = 0; hold_kick = 0;
      cur_time = 64'd100;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: key extremes, payload clamp, every kind
      c = make_cmd(KIND_FIND); c.key = '0; add_cmd(c);
      c = make_cmd(KIND_INSERT); c.key = '0; c.pay = 10'd0; add_cmd(c);
      c = make_cmd(KIND_INSERT); c.key = '1; c.pay = 10'd1023; add_cmd(c);
      c = make_cmd(KIND_INSERT); c.key = '1; c.pay = 10'd512; add_cmd(c);
      c = make_cmd(KIND_INSERT); c.key = '0; c.key.desc_index = 16'd1; c.pay = 10'd513;
      add_cmd(c);
      c = make_cmd(KIND_FIND); c.key = '1; add_cmd(c);
      c = make_cmd(KIND_FIND); c.key = '1; c.key.desc_type = 16'd0; add_cmd(c);
      c = make_cmd(KIND_DISPATCH); c.credit = 7'd0; c.now = cur_time + 64'd5000; add_cmd(c);
      c = make_cmd(KIND_DISPATCH); c.credit = 7'd64; c.now = cur_time + 64'd5000; add_cmd(c);
      c = make_cmd(KIND_DISPATCH); c.credit = 7'd127; c.now = cur_time + 64'd5000; add_cmd(c);
      c = make_cmd(KIND_DISPATCH); c.credit = 7'd1; c.now = cur_time + 64'd5001; add_cmd(c);
      c = make_cmd(KIND_RSV5); add_cmd(c);
      c = make_cmd(KIND_RSV6); add_cmd(c);
      c = make_cmd(KIND_RSV7); add_cmd(c);
      c = make_cmd(KIND_CLEAR); c.key.entity = '1; add_cmd(c);
      c = make_cmd(KIND_CLEAR); c.key.entity = 64'h1234; add_cmd(c);
      c = make_cmd(KIND_EXPIRE); c.now = cur_time; add_cmd(c);
      c = make_cmd(KIND_EXPIRE); c.now = cur_time + 64'd20000; add_cmd(c);
      c = make_cmd(KIND_FIND); c.key = '0; add_cmd(c);
      wait_drained();

      // random at reset values, with a long receiver stall up front
      hold_kick++;
      add_random(50);
      wait_drained();

      // fill the table to capacity, then overflow; dispatch requests everything stale
      write_reg(REG_MAX_AGE, '1);
      write_reg(REG_MIN_REQ, '0);
      for (int i = 0; i < NSLOTS + 6; i++) begin
         c = make_cmd(KIND_INSERT);
         c.key.model_id = 64'd5; c.key.entity = 64'd9;
         c.key.config_number = 16'(32'h8000 + i); c.key.desc_type = 16'($urandom);
         add_cmd(c);
      end
      add_random(20);
      c = make_cmd(KIND_DISPATCH); c.credit = 7'd64; c.now = cur_time + 64'd7; add_cmd(c);
      wait_drained();

      // expire everything older than now, never re-request
      write_reg(REG_MAX_AGE, '0);
      write_reg(REG_MIN_REQ, '1);
      add_random(40);
      wait_drained();

      // mid-range settings, no idling in the last part
      write_reg(REG_MAX_AGE, 64'($urandom_range(0, 20000)));
      write_reg(REG_MIN_REQ, 64'($urandom_range(0, 3000)));
      add_random(40);
      while (pending.size() > 20) @(posedge clock);
      no_idle = 1;
      wait_drained();

      if (errors == 0 && expected_rsp.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
